### design/bpm_pkg.sv
// ----------------------------------------------------------------------------
// bpm_pkg
// Shared constants and types for the bracket pair matcher.
// ----------------------------------------------------------------------------
package bpm_pkg;

    localparam int MAX_TOKENS  = 4096;
    localparam int STACK_DEPTH = 256;

    localparam int SYM_W     = 8;
    localparam int OUT_POS_W = 12;
    localparam int STATUS_W  = 3;
    localparam int POS_W     = $clog2(MAX_TOKENS + 1);
    localparam int COUNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W    = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
    localparam int CFG_IDX_W = 8;

    localparam logic [STATUS_W-1:0] ST_OK              = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNMATCHED_CLOSE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNMATCHED_OPEN  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG        = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_SYMBOL  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_SYMBOL = 8'd1;

    localparam logic [SYM_W-1:0] OPEN_SYMBOL_RST  = 8'd91;
    localparam logic [SYM_W-1:0] CLOSE_SYMBOL_RST = 8'd93;

    typedef struct packed {
        logic                 pair_valid;
        logic [OUT_POS_W-1:0] open_pos;
        logic [OUT_POS_W-1:0] close_pos;
        logic                 done_res;
        logic [STATUS_W-1:0]  status;
    } t_result;

endpackage

### design/bracket_pair_matcher.sv
// A result is registered in the output register, or in the skid on a stall.
// Throughput: one token per cycle while o_in_ready is high; the top of stack
// is a register, the entry below is prefetched (registered stack RAM read) each cycle.
// A two-entry output (register plus skid) keeps input ready registered.
// Reset: synchronous, active low; clears counters, error and output valids,
// and loads the default symbols. Stack RAM contents are undefined until written.
// ----------------------------------------------------------------------------
// bracket_pair_matcher
// Position stack that pairs opening and closing brackets of a token stream
// and reports balance status at the end of each program.
// ----------------------------------------------------------------------------
module bracket_pair_matcher (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bpm_pkg::SYM_W-1:0]     i_symbol,
    input  logic                          i_has_symbol,
    input  logic                          i_is_last,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_pair_valid,
    output logic [bpm_pkg::OUT_POS_W-1:0] o_open_pos,
    output logic [bpm_pkg::OUT_POS_W-1:0] o_close_pos,
    output logic                          o_done_res,
    output logic [bpm_pkg::STATUS_W-1:0]  o_status,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bpm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bpm_pkg::SYM_W-1:0]     i_cfg_data
);

    logic [bpm_pkg::SYM_W-1:0]     r_open_sym;
    logic [bpm_pkg::SYM_W-1:0]     r_close_sym;
    logic [bpm_pkg::POS_W-1:0]     r_pos;
    logic [bpm_pkg::POS_W-1:0]     n_pos;
    logic [bpm_pkg::COUNT_W-1:0]   r_count;
    logic [bpm_pkg::COUNT_W-1:0]   n_count;
    logic [bpm_pkg::STATUS_W-1:0]  r_err;
    logic [bpm_pkg::STATUS_W-1:0]  n_err;
    logic [bpm_pkg::OUT_POS_W-1:0] r_top;
    logic [bpm_pkg::OUT_POS_W-1:0] r_fwd;
    logic                          r_use_fwd;
    logic                          r_out_valid;
    logic                          r_skid_valid;
    bpm_pkg::t_result              r_out;
    bpm_pkg::t_result              r_skid;
    bpm_pkg::t_result              res;

    logic                          acc;
    logic                          too_long;
    logic                          tok;
    logic                          err_ok;
    logic                          is_open;
    logic                          is_close;
    logic                          stk_full;
    logic                          stk_empty;
    logic                          push;
    logic                          pop;
    logic                          res_valid;
    logic                          out_free;
    logic [bpm_pkg::STATUS_W-1:0]  fin_status;
    logic [bpm_pkg::OUT_POS_W-1:0] below;
    logic [bpm_pkg::OUT_POS_W-1:0] ram_rdata;
    logic [bpm_pkg::OUT_POS_W-1:0] cur_pos;
    logic [bpm_pkg::POS_W+bpm_pkg::OUT_POS_W-1:0] pos_ext;
    logic [bpm_pkg::COUNT_W-1:0]   waddr_full;
    logic [bpm_pkg::COUNT_W-1:0]   raddr_full;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skid_valid;
    assign acc         = i_in_valid && o_in_ready;

    assign pos_ext   = {{bpm_pkg::OUT_POS_W{1'b0}}, r_pos};
    assign cur_pos   = pos_ext[bpm_pkg::OUT_POS_W-1:0];
    assign too_long  = i_has_symbol && (r_pos >= bpm_pkg::POS_W'(bpm_pkg::MAX_TOKENS));
    assign tok       = i_has_symbol && !too_long;
    assign err_ok    = (r_err == bpm_pkg::ST_OK);
    assign is_open   = (i_symbol == r_open_sym);
    assign is_close  = !is_open && (i_symbol == r_close_sym);
    assign stk_full  = (r_count == bpm_pkg::COUNT_W'(bpm_pkg::STACK_DEPTH));
    assign stk_empty = (r_count == '0);
    assign push      = acc && tok && err_ok && is_open && !stk_full;
    assign pop       = acc && tok && err_ok && is_close && !stk_empty;
    assign below     = r_use_fwd ? r_fwd : ram_rdata;

    always_comb begin
        n_err = r_err;
        if (tok && err_ok && is_open && stk_full) begin
            n_err = bpm_pkg::ST_OVERFLOW;
        end else if (tok && err_ok && is_close && stk_empty) begin
            n_err = bpm_pkg::ST_UNMATCHED_CLOSE;
        end else if (too_long && err_ok) begin
            n_err = bpm_pkg::ST_TOO_LONG;
        end
    end

    always_comb begin
        n_count = r_count;
        if (push) begin
            n_count = r_count + 1'b1;
        end else if (pop) begin
            n_count = r_count - 1'b1;
        end
        if (acc && i_is_last) begin
            n_count = '0;
        end
    end

    always_comb begin
        n_pos = r_pos;
        if (acc && i_is_last) begin
            n_pos = '0;
        end else if (acc && tok) begin
            n_pos = r_pos + 1'b1;
        end
    end

    always_comb begin
        fin_status = n_err;
        if (n_err == bpm_pkg::ST_OK &&
            (push || (pop ? (r_count > bpm_pkg::COUNT_W'(1)) : (r_count != '0)))) begin
            fin_status = bpm_pkg::ST_UNMATCHED_OPEN;
        end
        res            = '0;
        res.pair_valid = pop && (!i_is_last || fin_status == bpm_pkg::ST_OK);
        if (res.pair_valid) begin
            res.open_pos  = r_top;
            res.close_pos = cur_pos;
        end
        res.done_res = i_is_last;
        if (i_is_last) begin
            res.status = fin_status;
        end
    end

    assign res_valid  = acc && (i_is_last || pop);
    assign out_free   = !r_out_valid || i_out_ready;
    assign waddr_full = r_count - 1'b1;
    assign raddr_full = n_count - 2'd2;

    bpm_ram #(
        .WIDTH (bpm_pkg::OUT_POS_W),
        .DEPTH (bpm_pkg::STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (push && !stk_empty),
        .i_waddr (waddr_full[bpm_pkg::ADDR_W-1:0]),
        .i_wdata (r_top),
        .i_raddr (raddr_full[bpm_pkg::ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_top <= cur_pos;
            r_fwd <= r_top;
        end else if (pop) begin
            r_top <= below;
        end
        if (r_skid_valid && out_free) begin
            r_out <= r_skid;
        end else if (res_valid && out_free) begin
            r_out <= res;
        end
        if (res_valid && !out_free) begin
            r_skid <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_sym   <= bpm_pkg::OPEN_SYMBOL_RST;
            r_close_sym  <= bpm_pkg::CLOSE_SYMBOL_RST;
            r_pos        <= '0;
            r_count      <= '0;
            r_err        <= bpm_pkg::ST_OK;
            r_use_fwd    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == bpm_pkg::CFG_OPEN_SYMBOL) begin
                    r_open_sym <= i_cfg_data;
                end else if (i_cfg_index == bpm_pkg::CFG_CLOSE_SYMBOL) begin
                    r_close_sym <= i_cfg_data;
                end
            end
            r_pos     <= n_pos;
            r_count   <= n_count;
            r_use_fwd <= push;
            if (acc) begin
                r_err <= i_is_last ? bpm_pkg::ST_OK : n_err;
            end
            if (r_skid_valid) begin
                if (out_free) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (res_valid) begin
                if (out_free) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pair_valid = r_out.pair_valid;
    assign o_open_pos   = r_out.open_pos;
    assign o_close_pos  = r_out.close_pos;
    assign o_done_res   = r_out.done_res;
    assign o_status     = r_out.status;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bpm_pkg::COUNT_W'(bpm_pkg::STACK_DEPTH))
        else $error("stack count beyond depth");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_is_last |=> r_count == '0 && r_pos == '0 && r_err == bpm_pkg::ST_OK)
        else $error("program state not cleared after last token");

    a_pair_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pair_valid |-> o_status == bpm_pkg::ST_OK)
        else $error("pair reported with failing status");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err != bpm_pkg::ST_OK && !(acc && i_is_last) |=> r_err == $past(r_err))
        else $error("error code changed before program end");
`endif

endmodule

### design/bpm_ram.sv
// ----------------------------------------------------------------------------
// bpm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sim/bracket_pair_matcher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bracket_pair_matcher_tb
// Streams bracket programs through the matcher and scores every pair and end
// report against a behavioral position stack. Covers default and changed
// bracket codes, stack limits, sticky errors, output back-pressure
// and randomized well-formed, broken and noisy programs.
// ----------------------------------------------------------------------------
module bracket_pair_matcher_tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 400;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic [bpm_pkg::SYM_W-1:0]     i_symbol = '0;
    logic                          i_has_symbol = 1'b0;
    logic                          i_is_last = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic                          o_pair_valid;
    logic [bpm_pkg::OUT_POS_W-1:0] o_open_pos;
    logic [bpm_pkg::OUT_POS_W-1:0] o_close_pos;
    logic                          o_done_res;
    logic [bpm_pkg::STATUS_W-1:0]  o_status;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [bpm_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [bpm_pkg::SYM_W-1:0]     i_cfg_data = '0;

    // shadow of the matcher
    logic [bpm_pkg::SYM_W-1:0]     open_code = bpm_pkg::OPEN_SYMBOL_RST;
    logic [bpm_pkg::SYM_W-1:0]     close_code = bpm_pkg::CLOSE_SYMBOL_RST;
    int                            tok_pos = 0;
    int                            depth = 0;
    logic [bpm_pkg::STATUS_W-1:0]  err_code = bpm_pkg::ST_OK;
    logic [bpm_pkg::OUT_POS_W-1:0] lifo [bpm_pkg::STACK_DEPTH];
    bpm_pkg::t_result              match_q [$];

    int   err_count = 0;
    int   cycle_count = 0;
    int   items_sent = 0;
    bit   in_gaps = 1'b0;
    logic out_gaps = 1'b0;
    logic hold_req = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left = 0;
    int   stall_left = 0;

    bracket_pair_matcher u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_symbol     (i_symbol),
        .i_has_symbol (i_has_symbol),
        .i_is_last    (i_is_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pair_valid (o_pair_valid),
        .o_open_pos   (o_open_pos),
        .o_close_pos  (o_close_pos),
        .o_done_res   (o_done_res),
        .o_status     (o_status),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bracket_pair_matcher test failed");
            $finish;
        end
    end

    // result side: long hold on request, random stall bursts otherwise
    always @(posedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken  <= 1'b1;
            hold_left   <= LONG_HOLD;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (out_gaps && $urandom_range(0, 9) == 0) begin
            stall_left  <= $urandom_range(0, 10);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic void match_token(logic [bpm_pkg::SYM_W-1:0] sym, logic has,
                                        logic last);
        bpm_pkg::t_result             r;
        logic                         hit;
        int                           cur;
        int                           opos;
        int                           cpos;
        logic [bpm_pkg::STATUS_W-1:0] st;
        hit  = 1'b0;
        opos = 0;
        cpos = 0;
        if (has) begin
            if (tok_pos >= bpm_pkg::MAX_TOKENS) begin
                if (err_code == bpm_pkg::ST_OK)
                    err_code = bpm_pkg::ST_TOO_LONG;
            end else begin
                cur     = tok_pos;
                tok_pos = tok_pos + 1;
                if (err_code == bpm_pkg::ST_OK) begin
                    if (sym == open_code) begin
                        if (depth >= bpm_pkg::STACK_DEPTH) begin
                            err_code = bpm_pkg::ST_OVERFLOW;
                        end else begin
                            lifo[depth] = cur[bpm_pkg::OUT_POS_W-1:0];
                            depth++;
                        end
                    end else if (sym == close_code) begin
                        if (depth == 0) begin
                            err_code = bpm_pkg::ST_UNMATCHED_CLOSE;
                        end else begin
                            depth--;
                            opos = lifo[depth];
                            cpos = cur;
                            hit  = 1'b1;
                        end
                    end
                end
            end
        end
        if (!last && !hit)
            return;
        st = bpm_pkg::ST_OK;
        if (last) begin
            st = err_code;
            if (st == bpm_pkg::ST_OK && depth != 0)
                st = bpm_pkg::ST_UNMATCHED_OPEN;
            if (st != bpm_pkg::ST_OK)
                hit = 1'b0;
        end
        r.pair_valid = hit;
        r.open_pos   = hit ? opos[bpm_pkg::OUT_POS_W-1:0] : '0;
        r.close_pos  = hit ? cpos[bpm_pkg::OUT_POS_W-1:0] : '0;
        r.done_res   = last;
        r.status     = last ? st : bpm_pkg::ST_OK;
        match_q.insert(match_q.size(), r);
        if (last) begin
            tok_pos  = 0;
            depth    = 0;
            err_code = bpm_pkg::ST_OK;
        end
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        begin
            if (err_count < 50)
                $display("mismatch on %s at cycle %0d: got %0d, want %0d",
                         field, cycle_count, got, want);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        bpm_pkg::t_result want;
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bpm_pkg::CFG_OPEN_SYMBOL:  open_code = i_cfg_data;
                bpm_pkg::CFG_CLOSE_SYMBOL: close_code = i_cfg_data;
                default: ;
            endcase
        end
        if (i_rst_n && i_in_valid && o_in_ready)
            match_token(i_symbol, i_has_symbol, i_is_last);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (match_q.size() == 0) begin
                report_mismatch("unrequested result, close_pos", o_close_pos, 0);
            end else begin
                want = match_q.pop_front();
                if (o_pair_valid !== want.pair_valid)
                    report_mismatch("pair_valid", o_pair_valid, want.pair_valid);
                if (o_open_pos !== want.open_pos)
                    report_mismatch("open_pos", o_open_pos, want.open_pos);
                if (o_close_pos !== want.close_pos)
                    report_mismatch("close_pos", o_close_pos, want.close_pos);
                if (o_done_res !== want.done_res)
                    report_mismatch("done_res", o_done_res, want.done_res);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
            end
        end
    end

    function automatic logic [bpm_pkg::SYM_W-1:0] plain_symbol(
        logic [bpm_pkg::SYM_W-1:0] oc, logic [bpm_pkg::SYM_W-1:0] cc);
        logic [bpm_pkg::SYM_W-1:0] s;
        s = bpm_pkg::SYM_W'($urandom_range(0, 255));
        while (s == oc || s == cc)
            s = bpm_pkg::SYM_W'($urandom_range(0, 255));
        return s;
    endfunction

    task automatic send_token(input logic [bpm_pkg::SYM_W-1:0] sym, input logic has,
                              input logic last);
        begin
            if (in_gaps && $urandom_range(0, 9) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            i_in_valid   <= 1'b1;
            i_symbol     <= sym;
            i_has_symbol <= has;
            i_is_last    <= last;
            @(posedge i_clk);
            while (!o_in_ready)
                @(posedge i_clk);
            if (has || last)
                items_sent++;
        end
    endtask

    task automatic wait_all_reported;
        begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
            while (match_q.size() != 0)
                @(negedge i_clk);
            repeat (4) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [bpm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bpm_pkg::SYM_W-1:0] val);
        begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= val;
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic set_brackets(input logic [bpm_pkg::SYM_W-1:0] oc,
                                input logic [bpm_pkg::SYM_W-1:0] cc);
        begin
            wait_all_reported();
            write_reg(bpm_pkg::CFG_OPEN_SYMBOL, oc);
            write_reg(bpm_pkg::CFG_CLOSE_SYMBOL, cc);
        end
    endtask

    task automatic test_basic_pairs;
        begin
            send_token(bpm_pkg::OPEN_SYMBOL_RST, 1'b1, 1'b0);
            send_token(8'h00, 1'b1, 1'b0);
            send_token(bpm_pkg::OPEN_SYMBOL_RST, 1'b0, 1'b0);
            send_token(bpm_pkg::CLOSE_SYMBOL_RST, 1'b1, 1'b0);
            send_token(8'hFF, 1'b0, 1'b1);
            // pair on the last token
            send_token(bpm_pkg::OPEN_SYMBOL_RST, 1'b1, 1'b0);
            send_token(8'hFF, 1'b1, 1'b0);
            send_token(bpm_pkg::CLOSE_SYMBOL_RST, 1'b1, 1'b1);
            // empty program
            send_token(8'h00, 1'b0, 1'b1);
            // unmatched close, later pair suppressed
            send_token(bpm_pkg::CLOSE_SYMBOL_RST, 1'b1, 1'b0);
            send_token(bpm_pkg::OPEN_SYMBOL_RST, 1'b1, 1'b0);
            send_token(bpm_pkg::CLOSE_SYMBOL_RST, 1'b1, 1'b0);
            send_token(8'h00, 1'b0, 1'b1);
            // unmatched open, last close dropped
            send_token(bpm_pkg::OPEN_SYMBOL_RST, 1'b1, 1'b0);
            send_token(bpm_pkg::OPEN_SYMBOL_RST, 1'b1, 1'b0);
            send_token(bpm_pkg::CLOSE_SYMBOL_RST, 1'b1, 1'b1);
            send_token(bpm_pkg::OPEN_SYMBOL_RST, 1'b1, 1'b0);
            send_token(8'h5A, 1'b0, 1'b1);
            wait_all_reported();
        end
    endtask

    task automatic test_symbol_registers;
        logic [bpm_pkg::CFG_IDX_W-1:0] spare_idx;
        begin
            set_brackets(8'h00, 8'hFF);
            send_token(8'h00, 1'b1, 1'b0);
            send_token(bpm_pkg::OPEN_SYMBOL_RST, 1'b1, 1'b0);
            send_token(8'hFF, 1'b1, 1'b1);
            set_brackets(8'hFF, 8'h00);
            spare_idx = bpm_pkg::CFG_IDX_W'($urandom_range(bpm_pkg::CFG_CLOSE_SYMBOL + 1,
                                                           255));
            write_reg(spare_idx, bpm_pkg::SYM_W'($urandom_range(0, 255)));
            send_token(8'hFF, 1'b1, 1'b0);
            send_token(8'hFF, 1'b1, 1'b0);
            send_token(8'h00, 1'b1, 1'b0);
            send_token(8'h00, 1'b1, 1'b1);
            // same code for both: always an open
            set_brackets(8'h07, 8'h07);
            send_token(8'h07, 1'b1, 1'b0);
            send_token(8'h07, 1'b1, 1'b0);
            send_token(8'h07, 1'b1, 1'b1);
            set_brackets(bpm_pkg::OPEN_SYMBOL_RST, bpm_pkg::CLOSE_SYMBOL_RST);
        end
    endtask

    task automatic test_stack_limits;
        int k;
        begin
            for (k = 0; k < bpm_pkg::STACK_DEPTH; k++)
                send_token(bpm_pkg::OPEN_SYMBOL_RST, 1'b1, 1'b0);
            for (k = 0; k < bpm_pkg::STACK_DEPTH - 1; k++)
                send_token(bpm_pkg::CLOSE_SYMBOL_RST, 1'b1, 1'b0);
            send_token(bpm_pkg::CLOSE_SYMBOL_RST, 1'b1, 1'b1);
            // overflow
            for (k = 0; k <= bpm_pkg::STACK_DEPTH; k++)
                send_token(bpm_pkg::OPEN_SYMBOL_RST, 1'b1, 1'b0);
            send_token(bpm_pkg::CLOSE_SYMBOL_RST, 1'b1, 1'b0);
            send_token(8'h00, 1'b0, 1'b1);
            wait_all_reported();
        end
    endtask

    task automatic test_output_stall;
        int k;
        begin
            hold_req <= 1'b1;
            for (k = 0; k < 40; k++) begin
                send_token(bpm_pkg::OPEN_SYMBOL_RST, 1'b1, 1'b0);
                send_token(bpm_pkg::CLOSE_SYMBOL_RST, 1'b1, 1'b0);
            end
            send_token(8'h00, 1'b0, 1'b1);
            wait_all_reported();
        end
    endtask

    task automatic run_random_phase(input logic [bpm_pkg::SYM_W-1:0] oc,
                                    input logic [bpm_pkg::SYM_W-1:0] cc,
                                    input int quota);
        int                        stop_at;
        int                        len;
        int                        mode;
        int                        nest;
        int                        k;
        int                        r;
        logic [bpm_pkg::SYM_W-1:0] sym;
        logic                      has;
        begin
            set_brackets(oc, cc);
            stop_at = items_sent + quota;
            while (items_sent < stop_at) begin
                len  = $urandom_range(0, 30);
                mode = $urandom_range(0, 9);    // 0-6 well formed, 7-8 broken, 9 noise
                nest = 0;
                for (k = 0; k < len; k++) begin
                    r   = $urandom_range(0, 9);
                    has = 1'b1;
                    if (mode == 9) begin
                        sym = bpm_pkg::SYM_W'($urandom_range(0, 255));
                        has = 1'($urandom_range(0, 1));
                    end else if (r < 4) begin
                        sym = oc;
                        nest++;
                    end else if (r < 8 && (nest > 0 || mode >= 7)) begin
                        sym = cc;
                        if (nest > 0)
                            nest--;
                    end else if (r == 8) begin
                        sym = bpm_pkg::SYM_W'($urandom_range(0, 255));
                        has = 1'b0;
                    end else begin
                        sym = plain_symbol(oc, cc);
                    end
                    send_token(sym, has, 1'b0);
                end
                if (mode < 7) begin
                    while (nest > 1) begin
                        send_token(cc, 1'b1, 1'b0);
                        nest--;
                    end
                end
                if (mode < 7 && nest > 0) begin
                    send_token(cc, 1'b1, 1'b1);
                end else begin
                    r = $urandom_range(0, 2);
                    if (r == 0)
                        send_token(bpm_pkg::SYM_W'($urandom_range(0, 255)), 1'b0, 1'b1);
                    else if (r == 1)
                        send_token(plain_symbol(oc, cc), 1'b1, 1'b1);
                    else
                        send_token(bpm_pkg::SYM_W'($urandom_range(0, 255)), 1'b1, 1'b1);
                end
            end
        end
    endtask

    task automatic test_random_programs;
        begin
            run_random_phase(8'h00, 8'hFF, 115);
            run_random_phase(8'hFF, 8'h00, 115);
            run_random_phase(8'h28, 8'h29, 115);
            run_random_phase(8'h07, 8'h07, 115);
            wait_all_reported();
            in_gaps = 1'b0;
            out_gaps <= 1'b0;
            run_random_phase(bpm_pkg::OPEN_SYMBOL_RST, bpm_pkg::CLOSE_SYMBOL_RST, 115);
            wait_all_reported();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        in_gaps = 1'b1;
        out_gaps <= 1'b1;
        test_basic_pairs();
        test_symbol_registers();
        test_stack_limits();
        test_output_stall();
        test_random_programs();
        repeat (8) @(posedge i_clk);
        if (err_count == 0 && match_q.size() == 0)
            $display("bracket_pair_matcher test passed");
        else
            $display("bracket_pair_matcher test failed");
        $finish;
    end

endmodule

### sim.f
design/bpm_pkg.sv
design/bpm_ram.sv
design/bracket_pair_matcher.sv
sim/bracket_pair_matcher_tb.sv
